### sv/pst_pkg.sv
// Shared types and codes for the page set table.
// Used by the controller, the datapath and the top level; depends on nothing.
package pst_pkg;

  // Operation carried by one input item.
  typedef enum logic [2:0] {
    ACT_PUSH    = 3'd0,
    ACT_POP     = 3'd1,
    ACT_GET     = 3'd2,
    ACT_SET     = 3'd3,
    ACT_REPLACE = 3'd4,
    ACT_REMOVE  = 3'd5,
    ACT_CLEAR   = 3'd6
  } action_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Read address source for the entry RAM.
  typedef enum logic [1:0] {
    RD_LAST,
    RD_INDEX,
    RD_SCAN
  } rd_sel_t;

  // Write address and data source for the entry RAM.
  typedef enum logic [1:0] {
    WR_PUSH,
    WR_SET,
    WR_REPL,
    WR_MOVE
  } wr_sel_t;

  // Update of the fill count.
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLEAR
  } cnt_op_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_FETCH,
    S_LAST,
    S_SCAN,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    scan_clr;
    logic    wr_en;
    wr_sel_t wr_sel;
    cnt_op_t cnt_op;
    logic    cap_last;
    logic    val_cap;
    logic    st_set;
    status_t st_code;
    logic    res_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t act;
    logic    is_empty;
    logic    is_full;
    logic    idx_ok;
    logic    scan_end;
    logic    cmp_valid;
    logic    match;
    logic    out_free;
  } dp_stat_t;

endpackage

### sv/pst_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Self-contained; no package dependency.
module pst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/pst_ctrl.sv
// Controller state machine for the page set table.
// Depends on pst_pkg for the state, command and status types.
module pst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pst_pkg::dp_stat_t stat,
  output pst_pkg::dp_cmd_t  cmd
);

  pst_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      pst_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = pst_pkg::S_DISPATCH;
        end
      end

      // Range checks, and the first memory access of push, pop, get, set and remove.
      pst_pkg::S_DISPATCH: begin
        state_next = pst_pkg::S_DONE;
        unique case (stat.act)
          pst_pkg::ACT_PUSH: begin
            if (stat.is_full) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = pst_pkg::ST_FULL;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = pst_pkg::WR_PUSH;
              cmd.cnt_op = pst_pkg::CNT_INC;
            end
          end
          pst_pkg::ACT_POP: begin
            if (stat.is_empty) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = pst_pkg::ST_RANGE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = pst_pkg::RD_LAST;
              cmd.cnt_op = pst_pkg::CNT_DEC;
              state_next = pst_pkg::S_FETCH;
            end
          end
          pst_pkg::ACT_GET: begin
            if (!stat.idx_ok) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = pst_pkg::ST_RANGE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = pst_pkg::RD_INDEX;
              state_next = pst_pkg::S_FETCH;
            end
          end
          pst_pkg::ACT_SET: begin
            if (!stat.idx_ok) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = pst_pkg::ST_RANGE;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = pst_pkg::WR_SET;
            end
          end
          pst_pkg::ACT_REPLACE: begin
            cmd.scan_clr = 1'b1;
            state_next   = pst_pkg::S_SCAN;
          end
          pst_pkg::ACT_REMOVE: begin
            if (stat.is_empty) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = pst_pkg::ST_RANGE;
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = pst_pkg::RD_LAST;
              cmd.scan_clr = 1'b1;
              state_next   = pst_pkg::S_LAST;
            end
          end
          pst_pkg::ACT_CLEAR: begin
            cmd.cnt_op = pst_pkg::CNT_CLEAR;
          end
          default: begin
          end
        endcase
      end

      // Read data for pop and get has arrived.
      pst_pkg::S_FETCH: begin
        cmd.val_cap = 1'b1;
        state_next  = pst_pkg::S_DONE;
      end

      // Remove: the last entry has arrived; a match there just shrinks the set.
      pst_pkg::S_LAST: begin
        cmd.cap_last = 1'b1;
        if (stat.match) begin
          cmd.cnt_op = pst_pkg::CNT_DEC;
          state_next = pst_pkg::S_DONE;
        end else begin
          state_next = pst_pkg::S_SCAN;
        end
      end

      // One read issued and one entry compared per cycle.
      pst_pkg::S_SCAN: begin
        if (!stat.scan_end) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pst_pkg::RD_SCAN;
        end
        if (stat.act == pst_pkg::ACT_REMOVE) begin
          if (stat.cmp_valid && stat.match) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = pst_pkg::WR_MOVE;
            cmd.cnt_op = pst_pkg::CNT_DEC;
            state_next = pst_pkg::S_DONE;
          end else if (stat.scan_end && !stat.cmp_valid) begin
            cmd.st_set  = 1'b1;
            cmd.st_code = pst_pkg::ST_NOTFOUND;
            state_next  = pst_pkg::S_DONE;
          end
        end else begin
          if (stat.cmp_valid && stat.match) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = pst_pkg::WR_REPL;
          end
          if (stat.scan_end && !stat.cmp_valid) begin
            state_next = pst_pkg::S_DONE;
          end
        end
      end

      // Hand the result to the output register once it is free.
      pst_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = pst_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = pst_pkg::S_IDLE;
      end
    endcase
  end

  // A result is loaded only when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> stat.out_free)
    else $error("result loaded into a busy output register");

  // An item leaves the dispatch state on the following cycle.
  a_dispatch_once: assert property (@(posedge clk) disable iff (rst)
    state == pst_pkg::S_DISPATCH |=> state != pst_pkg::S_DISPATCH)
    else $error("dispatch state held for more than one cycle");

  // Input items are taken only while the controller is idle.
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> state == pst_pkg::S_IDLE)
    else $error("input taken while an item is in flight");

endmodule

### sv/pst_datapath.sv
// Datapath of the page set table: operand registers, fill count, scan pointer,
// entry RAM and output register. Depends on pst_pkg and pst_ram.
module pst_datapath #(
  parameter int CAPACITY  = 64,
  parameter int PAGE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [2:0]        action,
  input  logic [5:0]        index,
  input  logic [31:0]       page,
  input  logic [31:0]       new_page,
  input  pst_pkg::dp_cmd_t  cmd,
  output pst_pkg::dp_stat_t stat,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [31:0]       value,
  output logic [6:0]        count,
  output logic [1:0]        status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > 6) ? CW : 6;

  // Operand registers.
  pst_pkg::action_t     op_action;
  logic [5:0]           op_index;
  logic [PAGE_BITS-1:0] op_page;
  logic [PAGE_BITS-1:0] op_new_page;

  // Control and scan state.
  logic [CW-1:0]        fill, fill_next;
  logic [CW-1:0]        scan_ptr;
  logic [CW-1:0]        scan_limit;
  logic                 cmp_valid;
  logic [AW-1:0]        cmp_addr;
  logic [PAGE_BITS-1:0] last_entry;

  // Pending result.
  logic [31:0]          res_value;
  pst_pkg::status_t     res_status;
  pst_pkg::status_t     out_status;

  // RAM ports.
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [PAGE_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [PAGE_BITS-1:0] rd_data;

  // Latch the operands of an accepted item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_action   <= pst_pkg::action_t'(action);
      op_index    <= index;
      op_page     <= PAGE_BITS'(page);
      op_new_page <= PAGE_BITS'(new_page);
    end
  end

  // Fill count update.
  always_comb begin
    unique case (cmd.cnt_op)
      pst_pkg::CNT_HOLD:  fill_next = fill;
      pst_pkg::CNT_INC:   fill_next = fill + CW'(1);
      pst_pkg::CNT_DEC:   fill_next = fill - CW'(1);
      pst_pkg::CNT_CLEAR: fill_next = '0;
      default:            fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // Read address selection.
  always_comb begin
    rd_en = cmd.rd_en;
    unique case (cmd.rd_sel)
      pst_pkg::RD_LAST:  rd_addr = AW'(fill - CW'(1));
      pst_pkg::RD_INDEX: rd_addr = AW'(op_index);
      pst_pkg::RD_SCAN:  rd_addr = AW'(scan_ptr);
      default:           rd_addr = AW'(scan_ptr);
    endcase
  end

  // Write address and data selection.
  always_comb begin
    wr_en = cmd.wr_en;
    unique case (cmd.wr_sel)
      pst_pkg::WR_PUSH: begin
        wr_addr = AW'(fill);
        wr_data = op_page;
      end
      pst_pkg::WR_SET: begin
        wr_addr = AW'(op_index);
        wr_data = op_page;
      end
      pst_pkg::WR_REPL: begin
        wr_addr = cmp_addr;
        wr_data = op_new_page;
      end
      pst_pkg::WR_MOVE: begin
        wr_addr = cmp_addr;
        wr_data = last_entry;
      end
      default: begin
        wr_addr = cmp_addr;
        wr_data = op_page;
      end
    endcase
  end

  // Scan pointer and compare stage; the compare comes in the cycle after the read.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_ptr  <= '0;
      cmp_valid <= 1'b0;
    end else begin
      if (cmd.scan_clr) begin
        scan_ptr <= '0;
      end else if (cmd.rd_en && cmd.rd_sel == pst_pkg::RD_SCAN) begin
        scan_ptr <= scan_ptr + CW'(1);
      end
      cmp_valid <= cmd.rd_en && cmd.rd_sel == pst_pkg::RD_SCAN;
    end
  end

  always_ff @(posedge clk) begin
    cmp_addr <= AW'(scan_ptr);
  end

  // Remove scans all but the last entry; replace scans them all.
  assign scan_limit = (op_action == pst_pkg::ACT_REMOVE) ? fill - CW'(1) : fill;

  always_ff @(posedge clk) begin
    if (cmd.cap_last) begin
      last_entry <= rd_data;
    end
  end

  // Pending result value and status.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_value  <= '0;
      res_status <= pst_pkg::ST_OK;
    end else begin
      if (cmd.val_cap) begin
        res_value <= 32'(rd_data);
      end
      if (cmd.st_set) begin
        res_status <= cmd.st_code;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      value      <= res_value;
      count      <= 7'(fill);
      out_status <= res_status;
    end
  end

  assign status = out_status;

  // Status to the controller.
  assign stat.act       = op_action;
  assign stat.is_empty  = (fill == '0);
  assign stat.is_full   = (fill >= CW'(CAPACITY));
  assign stat.idx_ok    = (IW'(op_index) < IW'(fill));
  assign stat.scan_end  = (scan_ptr >= scan_limit);
  assign stat.cmp_valid = cmp_valid;
  assign stat.match     = (rd_data == op_page);
  assign stat.out_free  = !out_valid || !out_stall;

  pst_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The fill count never exceeds the capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // Growing a full set or shrinking an empty one is a controller slip.
  a_cnt_inc: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_op == pst_pkg::CNT_INC |-> !stat.is_full)
    else $error("push on a full set");

  a_cnt_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_op == pst_pkg::CNT_DEC |-> !stat.is_empty)
    else $error("shrink of an empty set");

  // The scan never writes the entry it is reading in the same cycle.
  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write to the same entry in one cycle");

endmodule

### sv/page_set_table_core.sv
// Top level of the page set table: controller plus datapath.
// Depends on pst_pkg, pst_ctrl, pst_datapath and pst_ram.
//
// Fixed-capacity unordered set of pages with a fill count, one operation per
// item and one result per item. The block holds one item at a time: push, set,
// clear, an undefined action and errors need no RAM read, pop and get wait for
// one read, a remove that hits the last entry reads only that entry, and
// replace and remove otherwise scan the entry RAM through its single read port,
// one entry per cycle, then compare the final entry read. Each item also waits
// in its done state until the output register can take its result. A finished
// result sits in the output register, and a new item is accepted while it
// waits. A full push is dropped with status 1; empty or out-of-range accesses
// report status 2; a remove that finds no match reports status 3.
module page_set_table_core #(
  parameter int CAPACITY  = 64,
  parameter int PAGE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [5:0]  index,
  input  logic [31:0] page,
  input  logic [31:0] new_page,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] value,
  output logic [6:0]  count,
  output logic [1:0]  status
);

  pst_pkg::dp_cmd_t  cmd;
  pst_pkg::dp_stat_t stat;

  // Sequencer.
  pst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and result path.
  pst_datapath #(
    .CAPACITY  (CAPACITY),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .action    (action),
    .index     (index),
    .page      (page),
    .new_page  (new_page),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .value     (value),
    .count     (count),
    .status    (status)
  );

endmodule

### test/tb_top.sv
// Self-checking testbench for page_set_table_core, the page set table top level.
// Depends on pst_pkg for the action and status codes and on the RTL of the block.
`timescale 1ns / 100ps

module tb_top;

  localparam int SET_CAP   = 64;
  localparam int PAGE_W    = 32;
  localparam int HOLD_LEN  = 300;
  localparam int DRAIN_LEN = 80;

  // One result as the block reports it.
  typedef struct packed {
    logic [31:0]      value;
    logic [6:0]       count;
    pst_pkg::status_t status;
  } page_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  action = '0;
  logic [5:0]  index = '0;
  logic [31:0] page = '0;
  logic [31:0] new_page = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] value;
  logic [6:0]  count;
  logic [1:0]  status;

  // Shadow copy of the set, updated as each item is accepted.
  logic [31:0] held_pages [SET_CAP];
  int          held_count = 0;

  page_result_t expected_results[$];

  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int results_checked = 0;
  int items_sent = 0;
  int full_hits = 0;
  int op_tally[7];
  int status_tally[4];
  logic [31:0] page_pool[8];
  bit filling = 1'b1;

  page_set_table_core #(
    .CAPACITY (SET_CAP),
    .PAGE_BITS(PAGE_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .index    (index),
    .page     (page),
    .new_page (new_page),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value    (value),
    .count    (count),
    .status   (status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Applies one operation to the shadow set and returns the result it must give.
  function automatic page_result_t apply_page_op(input pst_pkg::action_t act,
                                                 input logic [5:0] idx,
                                                 input logic [31:0] pg,
                                                 input logic [31:0] npg);
    page_result_t r;
    logic [31:0]  last_pg;
    bit           hit;
    r.value  = '0;
    r.status = pst_pkg::ST_OK;
    unique case (act)
      pst_pkg::ACT_PUSH: begin
        if (held_count >= SET_CAP) begin
          r.status = pst_pkg::ST_FULL;
        end else begin
          held_pages[held_count] = pg;
          held_count++;
        end
      end
      pst_pkg::ACT_POP: begin
        if (held_count == 0) begin
          r.status = pst_pkg::ST_RANGE;
        end else begin
          held_count--;
          r.value = held_pages[held_count];
        end
      end
      pst_pkg::ACT_GET: begin
        if (int'(idx) >= held_count) r.status = pst_pkg::ST_RANGE;
        else r.value = held_pages[idx];
      end
      pst_pkg::ACT_SET: begin
        if (int'(idx) >= held_count) r.status = pst_pkg::ST_RANGE;
        else held_pages[idx] = pg;
      end
      pst_pkg::ACT_REPLACE: begin
        for (int i = 0; i < held_count; i++) begin
          if (held_pages[i] == pg) held_pages[i] = npg;
        end
      end
      pst_pkg::ACT_REMOVE: begin
        if (held_count == 0) begin
          r.status = pst_pkg::ST_RANGE;
        end else begin
          last_pg = held_pages[held_count - 1];
          if (last_pg == pg) begin
            held_count--;
          end else begin
            // Fill the first match with the last entry and shrink by one.
            r.status = pst_pkg::ST_NOTFOUND;
            hit = 1'b0;
            for (int i = 0; i < held_count - 1 && !hit; i++) begin
              if (held_pages[i] == pg) begin
                held_pages[i] = last_pg;
                held_count--;
                r.status = pst_pkg::ST_OK;
                hit = 1'b1;
              end
            end
          end
        end
      end
      pst_pkg::ACT_CLEAR: begin
        held_count = 0;
      end
      default: begin
      end
    endcase
    r.count = held_count[6:0];
    return r;
  endfunction

  // Offers one item, waits until it is taken and records what it must return.
  task automatic send_page_op(input pst_pkg::action_t act, input logic [5:0] idx,
                              input logic [31:0] pg, input logic [31:0] npg);
    page_result_t exp_r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    index    <= idx;
    page     <= pg;
    new_page <= npg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == pst_pkg::ACT_PUSH && held_count == SET_CAP) full_hits++;
    exp_r = apply_page_op(act, idx, pg, npg);
    expected_results.push_back(exp_r);
    op_tally[int'(act)]++;
    status_tally[int'(exp_r.status)]++;
    items_sent++;
  endtask

  // Receiver side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compares every accepted result with the oldest expectation.
  always @(posedge clk) begin
    page_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: value %h count %0d status %0d",
               value, count, status);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        results_checked++;
        if (value !== exp_r.value) begin
          $error("value mismatch: expected %h, got %h", exp_r.value, value);
          fail_count++;
        end
        if (count !== exp_r.count) begin
          $error("count mismatch: expected %0d, got %0d", exp_r.count, count);
          fail_count++;
        end
        if (status !== exp_r.status) begin
          $error("status mismatch: expected %0d, got %0d", exp_r.status, status);
          fail_count++;
        end
      end
    end
  end

  // Picks a page: mostly from a small pool or the set itself so matches happen.
  function automatic logic [31:0] pick_page();
    int r;
    r = $urandom_range(99);
    if (r < 60) return page_pool[$urandom_range(7)];
    if (r < 85 && held_count > 0) return held_pages[$urandom_range(held_count - 1)];
    return $urandom;
  endfunction

  // Picks an index, mostly a valid one.
  function automatic logic [5:0] pick_index();
    if (held_count > 0 && $urandom_range(99) < 75) return 6'($urandom_range(held_count - 1));
    return 6'($urandom_range(63));
  endfunction

  // Errors on the empty set, then every operation on a few entries.
  task automatic test_directed();
    send_page_op(pst_pkg::ACT_POP, 6'd0, 32'h0, 32'h0);
    send_page_op(pst_pkg::ACT_GET, 6'd0, 32'h0, 32'h0);
    send_page_op(pst_pkg::ACT_SET, 6'd63, 32'hFFFF_FFFF, 32'h0);
    send_page_op(pst_pkg::ACT_REMOVE, 6'd0, 32'h0, 32'h0);
    send_page_op(pst_pkg::ACT_REPLACE, 6'd0, 32'h0, 32'hFFFF_FFFF);
    send_page_op(pst_pkg::ACT_CLEAR, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_page_op(pst_pkg::ACT_PUSH, 6'd0, 32'h0, 32'h0);
    send_page_op(pst_pkg::ACT_PUSH, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_page_op(pst_pkg::ACT_PUSH, 6'd0, 32'h1234_5678, 32'h0);
    send_page_op(pst_pkg::ACT_PUSH, 6'd0, 32'h0, 32'h0);
    send_page_op(pst_pkg::ACT_GET, 6'd1, 32'h0, 32'h0);
    send_page_op(pst_pkg::ACT_GET, 6'd4, 32'h0, 32'h0);
    send_page_op(pst_pkg::ACT_GET, 6'd63, 32'h0, 32'h0);
    send_page_op(pst_pkg::ACT_REPLACE, 6'd0, 32'h0, 32'hDEAD_BEEF);
    send_page_op(pst_pkg::ACT_SET, 6'd3, 32'hA5A5_A5A5, 32'h0);
    send_page_op(pst_pkg::ACT_SET, 6'd4, 32'h5A5A_5A5A, 32'h0);
    // Remove the last entry, then the first one, then a page that is absent.
    send_page_op(pst_pkg::ACT_REMOVE, 6'd0, 32'hA5A5_A5A5, 32'h0);
    send_page_op(pst_pkg::ACT_REMOVE, 6'd0, 32'hDEAD_BEEF, 32'h0);
    send_page_op(pst_pkg::ACT_REMOVE, 6'd0, 32'h7777_7777, 32'h0);
    send_page_op(pst_pkg::ACT_POP, 6'd0, 32'h0, 32'h0);
    send_page_op(pst_pkg::ACT_GET, 6'd0, 32'h0, 32'h0);
    send_page_op(pst_pkg::ACT_CLEAR, 6'd0, 32'h0, 32'h0);
  endtask

  // Fills the set to capacity and pushes past it.
  task automatic test_full_set();
    while (held_count < SET_CAP) begin
      send_page_op(pst_pkg::ACT_PUSH, pick_index(), pick_page(), $urandom);
    end
    repeat (3) send_page_op(pst_pkg::ACT_PUSH, pick_index(), $urandom, $urandom);
    send_page_op(pst_pkg::ACT_GET, 6'd63, 32'h0, 32'h0);
    send_page_op(pst_pkg::ACT_SET, 6'd63, $urandom, 32'h0);
    send_page_op(pst_pkg::ACT_REPLACE, 6'd0, page_pool[0], page_pool[1]);
  endtask

  // Holds the receiver off for a long stretch while items keep coming.
  task automatic test_output_backpressure();
    hold_request = HOLD_LEN;
    repeat (10) send_page_op(pst_pkg::ACT_PUSH, pick_index(), pick_page(), $urandom);
    repeat (4) send_page_op(pst_pkg::ACT_GET, pick_index(), 32'h0, 32'h0);
  endtask

  // Random operations that swing the fill count between empty and full.
  task automatic test_random_ops(input int n_items);
    pst_pkg::action_t act;
    int               r;
    for (int n = 0; n < n_items; n++) begin
      if (held_count == SET_CAP && $urandom_range(3) == 0) filling = 1'b0;
      if (held_count == 0) filling = 1'b1;
      r = $urandom_range(99);
      if ($urandom_range(199) == 0) act = pst_pkg::ACT_CLEAR;
      else if (filling) begin
        if (r < 55) act = pst_pkg::ACT_PUSH;
        else if (r < 63) act = pst_pkg::ACT_POP;
        else if (r < 73) act = pst_pkg::ACT_GET;
        else if (r < 83) act = pst_pkg::ACT_SET;
        else if (r < 91) act = pst_pkg::ACT_REPLACE;
        else act = pst_pkg::ACT_REMOVE;
      end else begin
        if (r < 10) act = pst_pkg::ACT_PUSH;
        else if (r < 40) act = pst_pkg::ACT_POP;
        else if (r < 52) act = pst_pkg::ACT_GET;
        else if (r < 64) act = pst_pkg::ACT_SET;
        else if (r < 72) act = pst_pkg::ACT_REPLACE;
        else act = pst_pkg::ACT_REMOVE;
      end
      send_page_op(act, pick_index(), pick_page(), pick_page());
    end
  endtask

  // Run-time limit, well beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    page_pool[0] = 32'h0000_0000;
    page_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) page_pool[i] = $urandom;

    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 21;
    recv_idle_pct = 63;
    test_directed();
    test_full_set();
    test_random_ops(560);

    // The other way round.
    send_idle_pct = 63;
    recv_idle_pct = 21;
    test_random_ops(560);

    // No idling, with one long receiver hold-off first.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_random_ops(540);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);
    if (expected_results.size() != 0) fail_count++;

    $display("Sent %0d items: %0d push, %0d pop, %0d get, %0d set, %0d replace,",
             items_sent, op_tally[0], op_tally[1], op_tally[2], op_tally[3],
             op_tally[4]);
    $display("  %0d remove, %0d clear; checked %0d results: %0d ok, %0d full,",
             op_tally[5], op_tally[6], results_checked, status_tally[0],
             status_tally[1]);
    $display("  %0d range, %0d not found; %0d pushes hit a full set.",
             status_tally[2], status_tally[3], full_hits);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
